/* rtl/core/gpr_pkg.sv */
// Shared types, constants and helper functions of the pyramid reduce block.
package gpr_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int NCH        = 3;
    localparam int CHAN_W     = 8;
    localparam int DIM_W      = 12;
    localparam int POS_W      = 11;
    localparam int OPOS_W     = 10;
    localparam int VSUM_W     = 12;
    localparam int SUM_W      = 16;
    localparam int TAPS       = 5;
    localparam int LANES      = 4;
    localparam int BANKS      = 4;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

    typedef logic [CHAN_W-1:0]             chan_t;
    typedef chan_t [NCH-1:0]               pix_t;
    typedef pix_t [TAPS-1:0]               win_row_t;
    typedef win_row_t [TAPS-1:0]           win_t;
    typedef pix_t [BANKS-1:0]              bank_pix_t;
    typedef logic [NCH-1:0][VSUM_W-1:0]    vsum_col_t;
    typedef vsum_col_t [TAPS-1:0]          vsum_row_t;
    typedef logic [NCH-1:0][SUM_W-1:0]     sum_pix_t;

    typedef struct packed {
        sum_pix_t            sum;
        logic [OPOS_W-1:0]   col;
        logic [OPOS_W-1:0]   row;
        logic                done;
    } res_t;

    typedef res_t [LANES-1:0] res_set_t;

    function automatic logic [2:0] tap_w(input logic [2:0] t);
        logic [2:0] w;
        unique case (t)
            3'd0, 3'd4: w = 3'd1;
            3'd1, 3'd3: w = 3'd4;
            3'd2:       w = 3'd6;
            default:    w = 3'd0;
        endcase
        return w;
    endfunction

    // Window index of tap t for a centre d positions behind pos, with edge clamping.
    function automatic logic [2:0] clamp_idx(input logic [POS_W-1:0] pos,
                                             input logic [1:0] d,
                                             input logic [2:0] t);
        int rel;
        logic [2:0] idx;
        rel = int'(t) - 2 - int'(d);
        if (int'(pos) + rel < 0) begin
            idx = 3'(4 - int'(pos));
        end
        else if (rel > 0) begin
            idx = 3'd4;
        end
        else begin
            idx = 3'(4 + rel);
        end
        return idx;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(2)) begin
            r = DIM_W'(2);
        end
        else if (v > hi) begin
            r = hi;
        end
        else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/gpr_line_store.sv */
// Line memory holding the four prior rows, one bank per row modulo four.
module gpr_line_store
(
    input  logic                            clk,
    input  logic                            en,
    input  logic                            wr_en,
    input  logic [1:0]                      wr_bank,
    input  logic [gpr_pkg::POS_W-1:0]       addr,
    input  gpr_pkg::pix_t                   wr_data,
    output gpr_pkg::bank_pix_t              rd_data
);

    gpr_pkg::bank_pix_t rd_data_reg;

    for (genvar b = 0; b < gpr_pkg::BANKS; b++) begin : g_bank
        gpr_pkg::pix_t mem [gpr_pkg::MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                mem[addr] <= wr_data;
            end
            if (en)
            begin
                rd_data_reg[b] <= mem[addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/gpr_row_lane.sv */
// Vertical filter lane: clamped five-tap column sums for one output row.
module gpr_row_lane
(
    input  logic                        clk,
    input  logic                        en,
    input  gpr_pkg::win_t               win,
    input  logic [gpr_pkg::POS_W-1:0]   row,
    input  logic [1:0]                  back,
    output gpr_pkg::vsum_row_t          vsum
);

    gpr_pkg::vsum_row_t vsum_next;
    gpr_pkg::vsum_row_t vsum_reg;

    always_comb
    begin
        logic [2:0]                   idx;
        logic [gpr_pkg::VSUM_W-1:0]   acc;
        for (int j = 0; j < gpr_pkg::TAPS; j++) begin
            for (int ch = 0; ch < gpr_pkg::NCH; ch++) begin
                acc = '0;
                for (int t = 0; t < gpr_pkg::TAPS; t++) begin
                    idx = gpr_pkg::clamp_idx(row, back, 3'(t));
                    acc = acc + gpr_pkg::VSUM_W'(gpr_pkg::tap_w(3'(t)))
                              * gpr_pkg::VSUM_W'(win[idx][j][ch]);
                end
                vsum_next[j][ch] = acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vsum_reg <= vsum_next;
        end
    end

    assign vsum = vsum_reg;

endmodule

/* rtl/core/gpr_col_lane.sv */
// Horizontal filter lane: clamped five-tap sum over the column sums.
module gpr_col_lane
(
    input  gpr_pkg::vsum_row_t          vsum,
    input  logic [gpr_pkg::POS_W-1:0]   col,
    input  logic [1:0]                  back,
    output gpr_pkg::sum_pix_t           sum
);

    always_comb
    begin
        logic [2:0]                  idx;
        logic [gpr_pkg::SUM_W-1:0]   acc;
        for (int ch = 0; ch < gpr_pkg::NCH; ch++) begin
            acc = '0;
            for (int t = 0; t < gpr_pkg::TAPS; t++) begin
                idx = gpr_pkg::clamp_idx(col, back, 3'(t));
                acc = acc + gpr_pkg::SUM_W'(gpr_pkg::tap_w(3'(t)))
                          * gpr_pkg::SUM_W'(vsum[idx][ch]);
            end
            sum[ch] = acc;
        end
    end

endmodule

/* rtl/core/gpr_merge.sv */
// Merge stage: holds the lane results of one pixel and sends them out in order.
module gpr_merge
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [gpr_pkg::LANES-1:0]           load_mask,
    input  gpr_pkg::res_set_t                   load_res,
    output logic                                adv,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [71:0]                         m_tdata, // red, green, blue, col, row, pad
    output logic                                m_tlast,
    output logic                                m_tuser  // frame_done
);

    logic [gpr_pkg::LANES-1:0] pending_reg;
    gpr_pkg::res_set_t         res_reg;
    logic [gpr_pkg::LANES-1:0] first;
    logic [gpr_pkg::LANES-1:0] rest;
    gpr_pkg::res_t             sel;

    always_comb
    begin
        first = pending_reg & (~pending_reg + gpr_pkg::LANES'(1));
        rest  = pending_reg & ~first;
        sel   = res_reg[0];
        for (int l = gpr_pkg::LANES - 1; l >= 0; l--) begin
            if (first[l])
            begin
                sel = res_reg[l];
            end
        end
    end

    assign adv      = (pending_reg == '0) || ((rest == '0) && m_tready);
    assign m_tvalid = (pending_reg != '0);
    assign m_tlast  = (rest == '0);
    assign m_tuser  = sel.done;
    assign m_tdata  = {4'b0, sel.row, sel.col, sel.sum[2], sel.sum[1], sel.sum[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (adv)
        begin
            pending_reg <= load_mask;
        end
        else if (m_tready)
        begin
            pending_reg <= rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= load_res;
        end
    end

endmodule

/* rtl/core/gaussian_pyramid_reduce.sv */
// Top level of the 5x5 binomial pyramid reduce filter for RGB pixel streams.
//
//   channel  direction  payload
//   s_       in         tdata: red, green, blue
//   m_       out        tdata: out_red, out_green, out_blue, out_col, out_row;
//                       tlast: last_of_run; tuser: frame_done
//   cfg_     in         cfg_index, cfg_data (frame_width, frame_height)
//
// One pixel is taken per cycle while the pipeline advances; its results pass the s1,
// s2 and s3 registers and the merge stage, which sends them one per cycle and holds
// s_tready low until the last is sent; output stalls hold the whole pipeline.
// Reset needs no clearing pass; the line memory is never cleared.
module gaussian_pyramid_reduce
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,  // red, green, blue
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [71:0]                       m_tdata,  // red, green, blue, col, row, pad
    output logic                              m_tlast,  // last_of_run
    output logic                              m_tuser,  // frame_done
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpr_pkg::DIM_W-1:0]         cfg_data
);

    localparam int PW = gpr_pkg::POS_W;
    localparam int DW = gpr_pkg::DIM_W;
    localparam int OW = gpr_pkg::OPOS_W;

    logic              adv;
    logic              accept;
    logic              cfg_hit;
    logic [DW-1:0]     width_reg;
    logic [DW-1:0]     height_reg;
    logic [DW-1:0]     w_eff;
    logic [DW-1:0]     h_eff;
    logic [PW-1:0]     col_reg;
    logic [PW-1:0]     row_reg;
    logic [PW-1:0]     col_next;
    logic [PW-1:0]     row_next;
    logic [DW-1:0]     col_inc;
    logic [DW-1:0]     row_inc;

    logic              s1_valid_reg;
    gpr_pkg::pix_t     s1_px_reg;
    logic [PW-1:0]     s1_row_reg;
    logic [PW-1:0]     s1_col_reg;
    gpr_pkg::bank_pix_t rd_data;
    gpr_pkg::win_t     win_reg;

    logic              s2_valid_reg;
    logic [PW-1:0]     s2_row_reg;
    logic [PW-1:0]     s2_col_reg;
    logic [1:0]        row_ok;
    logic [1:0]        col_ok;
    logic [1:0]        row_b_back;
    logic [1:0]        col_b_back;
    logic [PW-1:0]     oy_a_full;
    logic [PW-1:0]     oy_b_full;
    logic [PW-1:0]     ox_a_full;
    logic [PW-1:0]     ox_b_full;

    logic              s3_valid_reg;
    logic [1:0]        s3_row_ok_reg;
    logic [1:0]        s3_col_ok_reg;
    logic [1:0]        s3_col_b_back_reg;
    logic [PW-1:0]     s3_col_reg;
    logic [1:0][OW-1:0] s3_oy_reg;
    logic [1:0][OW-1:0] s3_ox_reg;

    gpr_pkg::vsum_row_t vsum [2];
    gpr_pkg::sum_pix_t  lane_sum [gpr_pkg::LANES];
    logic [gpr_pkg::LANES-1:0] load_mask;
    gpr_pkg::res_set_t  load_res;
    logic [PW-1:0]     half_w_m1;
    logic [PW-1:0]     half_h_m1;

    assign cfg_ready = 1'b1;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign cfg_hit   = cfg_valid && ((cfg_index == gpr_pkg::CFG_FRAME_WIDTH)
                                  || (cfg_index == gpr_pkg::CFG_FRAME_HEIGHT));

    assign w_eff = gpr_pkg::clamp_size(width_reg, DW'(gpr_pkg::MAX_WIDTH));
    assign h_eff = gpr_pkg::clamp_size(height_reg, DW'(gpr_pkg::MAX_HEIGHT));

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + DW'(1);
        row_inc  = {1'b0, row_reg} + DW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[PW-1:0];
        end
        else
        begin
            col_next = col_inc[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(640);
            height_reg <= DW'(480);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_hit)
        begin
            if (cfg_index == gpr_pkg::CFG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    gpr_line_store u_line_store
    (
        .clk     (clk),
        .en      (adv),
        .wr_en   (accept),
        .wr_bank (row_reg[1:0]),
        .addr    (col_reg),
        .wr_data (s_tdata),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                for (int k = 0; k < gpr_pkg::TAPS; k++) begin
                    for (int j = 0; j < gpr_pkg::TAPS - 1; j++) begin
                        win_reg[k][j] <= win_reg[k][j+1];
                    end
                end
                for (int k = 0; k < gpr_pkg::BANKS; k++) begin
                    win_reg[k][gpr_pkg::TAPS-1] <= rd_data[2'(s1_row_reg[1:0] + 2'(k))];
                end
                win_reg[gpr_pkg::TAPS-1][gpr_pkg::TAPS-1] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg         <= s_tdata;
            s1_row_reg        <= row_reg;
            s1_col_reg        <= col_reg;
            s2_row_reg        <= s1_row_reg;
            s2_col_reg        <= s1_col_reg;
            s3_row_ok_reg     <= row_ok;
            s3_col_ok_reg     <= col_ok;
            s3_col_b_back_reg <= col_b_back;
            s3_col_reg        <= s2_col_reg;
            s3_oy_reg[0]      <= oy_a_full[PW-1:1];
            s3_oy_reg[1]      <= oy_b_full[PW-1:1];
            s3_ox_reg[0]      <= ox_a_full[PW-1:1];
            s3_ox_reg[1]      <= ox_b_full[PW-1:1];
        end
    end

    // Lane A is the centre two behind, lane B the extra centre at the far edge.
    always_comb
    begin
        row_ok[0]  = s2_row_reg[0] && (s2_row_reg >= PW'(3));
        row_ok[1]  = ({1'b0, s2_row_reg} == (h_eff - DW'(1)));
        col_ok[0]  = s2_col_reg[0] && (s2_col_reg >= PW'(3));
        col_ok[1]  = ({1'b0, s2_col_reg} == (w_eff - DW'(1)));
        row_b_back = s2_row_reg[0] ? 2'd0 : 2'd1;
        col_b_back = s2_col_reg[0] ? 2'd0 : 2'd1;
        oy_a_full  = s2_row_reg - PW'(3);
        oy_b_full  = s2_row_reg - PW'(row_b_back) - PW'(1);
        ox_a_full  = s2_col_reg - PW'(3);
        ox_b_full  = s2_col_reg - PW'(col_b_back) - PW'(1);
    end

    gpr_row_lane u_row_a
    (
        .clk  (clk),
        .en   (adv),
        .win  (win_reg),
        .row  (s2_row_reg),
        .back (2'd2),
        .vsum (vsum[0])
    );

    gpr_row_lane u_row_b
    (
        .clk  (clk),
        .en   (adv),
        .win  (win_reg),
        .row  (s2_row_reg),
        .back (row_b_back),
        .vsum (vsum[1])
    );

    for (genvar l = 0; l < gpr_pkg::LANES; l++) begin : g_col
        gpr_col_lane u_col
        (
            .vsum (vsum[l / 2]),
            .col  (s3_col_reg),
            .back ((l % 2 == 0) ? 2'd2 : s3_col_b_back_reg),
            .sum  (lane_sum[l])
        );
    end

    assign half_w_m1 = w_eff[DW-1:1] - PW'(1);
    assign half_h_m1 = h_eff[DW-1:1] - PW'(1);

    always_comb
    begin
        for (int l = 0; l < gpr_pkg::LANES; l++) begin
            load_mask[l]    = s3_valid_reg && s3_row_ok_reg[l / 2] && s3_col_ok_reg[l % 2];
            load_res[l].sum = lane_sum[l];
            load_res[l].row = s3_oy_reg[l / 2];
            load_res[l].col = s3_ox_reg[l % 2];
            load_res[l].done = ({1'b0, s3_oy_reg[l / 2]} == half_h_m1)
                            && ({1'b0, s3_ox_reg[l % 2]} == half_w_m1);
        end
    end

    gpr_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_mask (load_mask),
        .load_res  (load_res),
        .adv       (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTH
    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({2'b0, m_tdata[67:58]} < {1'b0, h_eff[DW-1:1]}))
        else $error("output row outside the reduced frame");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end result is not the last of its pixel");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_hit && (col_inc >= w_eff)) |=> (col_reg == '0))
        else $error("column counter did not wrap at the line end");
`endif

endmodule

/* dv/tb_gaussian_pyramid_reduce.sv */
// Self-checking testbench for the 5x5 binomial pyramid reduce block.
module tb_gaussian_pyramid_reduce;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 130;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last_of_run;
        logic        frame_done;
    } filt_res_t;

    typedef struct {
        bit                            is_cfg;
        logic [gpr_pkg::CFG_IDX_W-1:0] index;
        logic [23:0]                   value;
        bit                            typed;
        logic [15:0]                   typed_sum;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [23:0]                   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [71:0]                   m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [gpr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gpr_pkg::DIM_W-1:0]     cfg_data;

    filt_res_t   pending_q[$];
    logic [23:0] img_rows [0:7][0:gpr_pkg::MAX_WIDTH-1];
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    int          row_pos;
    int          col_pos;
    int          send_idle;
    int          recv_idle;
    int          errors;
    int          pixels_sent;
    int          results_seen;
    int          cfg_writes;
    int          cycles;

    gaussian_pyramid_reduce dut (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int clampi(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int eff_size(input logic [11:0] v, input int hi);
        return clampi(int'(v), 2, hi);
    endfunction

    task automatic predict_pixel(input logic [23:0] px);
        int w, h, r, c, cy, cx, dy, dx, ch, sum;
        int wt [5];
        filt_res_t e;
        filt_res_t batch[$];
        logic [23:0] p;
        wt = '{1, 4, 6, 4, 1};
        w = eff_size(width_reg, gpr_pkg::MAX_WIDTH);
        h = eff_size(height_reg, gpr_pkg::MAX_HEIGHT);
        r = (row_pos >= h) ? 0 : row_pos;
        c = (col_pos >= w) ? 0 : col_pos;
        img_rows[r % 8][c] = px;
        for (cy = r - 2; cy <= r; cy++)
        begin
            if (cy < 1 || cy % 2 == 0 || (cy - 1) / 2 >= h / 2 || clampi(cy + 2, 0, h - 1) != r)
                continue;
            for (cx = c - 2; cx <= c; cx++)
            begin
                if (cx < 1 || cx % 2 == 0 || (cx - 1) / 2 >= w / 2
                    || clampi(cx + 2, 0, w - 1) != c)
                    continue;
                for (ch = 0; ch < 3; ch++)
                begin
                    sum = 0;
                    for (dy = -2; dy <= 2; dy++)
                        for (dx = -2; dx <= 2; dx++)
                        begin
                            p = img_rows[clampi(cy + dy, 0, h - 1) % 8][clampi(cx + dx, 0, w - 1)];
                            sum += wt[dy + 2] * wt[dx + 2] * int'(p[8 * ch +: 8]);
                        end
                    if (ch == 0) e.red = sum[15:0];
                    else if (ch == 1) e.green = sum[15:0];
                    else e.blue = sum[15:0];
                end
                e.col = 10'((cx - 1) / 2);
                e.row = 10'((cy - 1) / 2);
                e.last_of_run = 1'b0;
                e.frame_done = ((cy - 1) / 2 == h / 2 - 1) && ((cx - 1) / 2 == w / 2 - 1);
                batch.push_back(e);
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[i])
            pending_q.push_back(batch[i]);
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic send_pixel(input logic [23:0] px);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = px;
        do @(posedge clk); while (!s_tready);
        predict_pixel(px);
        pixels_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [gpr_pkg::CFG_IDX_W-1:0] idx, input logic [11:0] val);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == gpr_pkg::CFG_FRAME_WIDTH || idx == gpr_pkg::CFG_FRAME_HEIGHT)
        begin
            if (idx == gpr_pkg::CFG_FRAME_WIDTH) width_reg = val;
            else height_reg = val;
            row_pos = 0;
            col_pos = 0;
        end
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            filt_res_t e;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result beat, tdata=%h", m_tdata);
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (m_tdata[15:0] !== e.red)
                begin
                    $error("out_red expected %0d actual %0d", e.red, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== e.green)
                begin
                    $error("out_green expected %0d actual %0d", e.green, m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[47:32] !== e.blue)
                begin
                    $error("out_blue expected %0d actual %0d", e.blue, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[57:48] !== e.col)
                begin
                    $error("out_col expected %0d actual %0d", e.col, m_tdata[57:48]);
                    errors++;
                end
                if (m_tdata[67:58] !== e.row)
                begin
                    $error("out_row expected %0d actual %0d", e.row, m_tdata[67:58]);
                    errors++;
                end
                if (m_tlast !== e.last_of_run)
                begin
                    $error("last_of_run expected %0d actual %0d", e.last_of_run, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.frame_done)
                begin
                    $error("frame_done expected %0d actual %0d", e.frame_done, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t dir_tbl[$];
        int phase, n, w, h, frames, cut;
        bit paused;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = gpr_pkg::CFG_FRAME_WIDTH;
        cfg_data = '0;
        width_reg = 12'd640;
        height_reg = 12'd480;
        row_pos = 0;
        col_pos = 0;
        errors = 0;
        pixels_sent = 0;
        results_seen = 0;
        cfg_writes = 0;
        cycles = 0;
        send_idle = 19;
        recv_idle = 58;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_tbl = '{
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h000000, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hFFFFFF, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h123456, 0, 16'd0},
            '{1, gpr_pkg::CFG_FRAME_WIDTH, 24'd2, 0, 16'd0},
            '{1, gpr_pkg::CFG_FRAME_HEIGHT, 24'd2, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hFFFFFF, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hFFFFFF, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hFFFFFF, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hFFFFFF, 1, 16'd65280},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h000000, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h000000, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h000000, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h000000, 1, 16'd0},
            '{1, gpr_pkg::CFG_FRAME_WIDTH, 24'd0, 0, 16'd0},
            '{1, gpr_pkg::CFG_FRAME_HEIGHT, 24'd1, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hFF00FF, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h00FF00, 0, 16'd0},
            '{1, 4'd7, 24'd3, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h800001, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h7F80FE, 0, 16'd0},
            '{1, gpr_pkg::CFG_FRAME_WIDTH, 24'd4095, 0, 16'd0},
            '{1, gpr_pkg::CFG_FRAME_HEIGHT, 24'd4095, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hAAAAAA, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h555555, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'hFFFFFF, 0, 16'd0},
            '{0, gpr_pkg::CFG_FRAME_WIDTH, 24'h000000, 0, 16'd0}
        };
        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].is_cfg)
                write_reg(dir_tbl[i].index, dir_tbl[i].value[11:0]);
            else
            begin
                send_pixel(dir_tbl[i].value);
                if (dir_tbl[i].typed)
                begin
                    pending_q[pending_q.size() - 1].red = dir_tbl[i].typed_sum;
                    pending_q[pending_q.size() - 1].green = dir_tbl[i].typed_sum;
                    pending_q[pending_q.size() - 1].blue = dir_tbl[i].typed_sum;
                end
            end
        end

        paused = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 19 : ((phase == 1) ? 58 : 0);
            recv_idle = (phase == 0) ? 58 : ((phase == 1) ? 19 : 0);
            n = 0;
            while (n < RANDOM_PER_PHASE)
            begin
                if ($urandom_range(11) == 0)
                begin
                    w = ($urandom_range(1) == 1) ? 4095 : 2048;
                    h = $urandom_range(2, 3);
                    frames = 0;
                    cut = $urandom_range(4, 12);
                end
                else
                begin
                    w = $urandom_range(2, 9);
                    h = $urandom_range(2, 8);
                    frames = $urandom_range(1, 2);
                    cut = ($urandom_range(5) == 0) ? $urandom_range(1, w * h - 1) : 0;
                end
                write_reg(gpr_pkg::CFG_FRAME_WIDTH, 12'(w));
                write_reg(gpr_pkg::CFG_FRAME_HEIGHT, 12'(h));
                if ($urandom_range(7) == 0)
                    write_reg(4'($urandom_range(2, 15)), 12'($urandom));
                for (int f = 0; f < frames && n < RANDOM_PER_PHASE; f++)
                    for (int k = 0; k < w * h && n < RANDOM_PER_PHASE; k++)
                    begin
                        send_pixel(24'($urandom));
                        n++;
                        if (phase == 1 && !paused && k == (w * h) / 2)
                        begin
                            paused = 1;
                            while (pending_q.size() != 0) @(posedge clk);
                            @(negedge clk);
                        end
                    end
                for (int k = 0; k < cut && n < RANDOM_PER_PHASE; k++)
                begin
                    send_pixel(24'($urandom));
                    n++;
                end
            end
        end

        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d pixels, %0d filtered results and %0d register writes,",
                 pixels_sent, results_seen, cfg_writes);
        $display("over frame sizes from the clamped minimum to the widest line.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
